>>> rtl/core/apl_pkg.sv
// ----------------------------------------------------------------------------
// apl_pkg
// Shared types and constants for the ASCII position line parser.
// ----------------------------------------------------------------------------
package apl_pkg;

  localparam int unsigned LEN_W = 8;

  localparam logic [3:0] PH_P      = 4'd0;
  localparam logic [3:0] PH_O      = 4'd1;
  localparam logic [3:0] PH_S      = 4'd2;
  localparam logic [3:0] PH_C      = 4'd3;
  localparam logic [3:0] PH_MODE   = 4'd4;
  localparam logic [3:0] PH_SEQ    = 4'd5;
  localparam logic [3:0] PH_X      = 4'd6;
  localparam logic [3:0] PH_Y      = 4'd7;
  localparam logic [3:0] PH_DSTART = 4'd8;
  localparam logic [3:0] PH_DDIG   = 4'd9;
  localparam logic [3:0] PH_REST   = 4'd10;
  localparam logic [3:0] PH_FAIL   = 4'd11;

  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_O     = 8'h4F;
  localparam logic [7:0] CHAR_S     = 8'h53;

  localparam logic [15:0] X_OFFSET_RESET = 16'd305;
  localparam logic [15:0] Y_OFFSET_RESET = 16'd235;

  localparam logic CFG_X_OFFSET = 1'b0;
  localparam logic CFG_Y_OFFSET = 1'b1;

  typedef struct packed {
    logic        target_valid;
    logic [15:0] distance;
    logic [15:0] move_y;
    logic [15:0] move_x;
    logic [15:0] target_y;
    logic [15:0] target_x;
    logic [15:0] sequence_res;
    logic [7:0]  mode;
  } result_t;

  function automatic logic [15:0] dec16(input logic [15:0] acc, input logic [3:0] d);
    dec16 = {acc[12:0], 3'b000} + {acc[14:0], 1'b0} + {12'd0, d};
  endfunction

  function automatic logic [7:0] dec8(input logic [7:0] acc, input logic [3:0] d);
    dec8 = {acc[4:0], 3'b000} + {acc[6:0], 1'b0} + {4'd0, d};
  endfunction

endpackage

>>> rtl/core/ascii_position_line_parser.sv
// ----------------------------------------------------------------------------
// ascii_position_line_parser
// Parses "POS,mode,seq,x,y,dist" lines from a byte stream into result beats.
// The newline byte is registered first, then its result is loaded into the output register that drives m_tvalid.
// Throughput: one byte per cycle, limited only by the sink stalling the
// result register. Reset clears the parse state and loads the offset defaults.
// ----------------------------------------------------------------------------
module ascii_position_line_parser #(
  parameter int unsigned MAX_LINE_LEN = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // rx_byte
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [103:0]  m_tdata,   // mode, sequence_res, target_x, target_y,
                                   // move_x, move_y, distance
  output logic          m_tuser,   // target_valid
  input  logic          cfg_we,
  input  logic          cfg_addr,
  input  logic [15:0]   cfg_wdata
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             advance;
  logic             step;
  logic             res_fire;
  logic [15:0]      x_offset;
  logic [15:0]      y_offset;
  apl_pkg::result_t res;
  apl_pkg::result_t out_res;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign step     = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset <= apl_pkg::X_OFFSET_RESET;
      y_offset <= apl_pkg::Y_OFFSET_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        apl_pkg::CFG_X_OFFSET: x_offset <= cfg_wdata;
        apl_pkg::CFG_Y_OFFSET: y_offset <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  apl_parse #(
    .MAX_LINE_LEN (MAX_LINE_LEN)
  ) u_parse (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .rx_byte  (in_byte),
    .x_offset (x_offset),
    .y_offset (y_offset),
    .res_fire (res_fire),
    .res      (res)
  );

  apl_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_fire),
    .load_data (res),
    .ready     (m_tready),
    .valid     (m_tvalid),
    .data      (out_res)
  );

  assign m_tdata = {out_res.distance, out_res.move_y, out_res.move_x, out_res.target_y,
                    out_res.target_x, out_res.sequence_res, out_res.mode};
  assign m_tuser = out_res.target_valid;

endmodule

>>> rtl/core/apl_parse.sv
// ----------------------------------------------------------------------------
// apl_parse
// Per-byte line parse state and result formation for one registered byte.
// ----------------------------------------------------------------------------
module apl_parse #(
  parameter int unsigned MAX_LINE_LEN = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  input  logic [15:0]         x_offset,
  input  logic [15:0]         y_offset,
  output logic                res_fire,
  output apl_pkg::result_t    res
);

  logic [3:0]               phase;
  logic [apl_pkg::LEN_W-1:0] line_length;
  logic [7:0]               mode_accum;
  logic [15:0]              sequence_accum;
  logic [15:0]              x_accum;
  logic [15:0]              y_accum;
  logic [15:0]              distance_accum;
  logic                     distance_negative;

  logic [3:0]               phase_next;
  logic [apl_pkg::LEN_W-1:0] line_length_next;
  logic [7:0]               mode_accum_next;
  logic [15:0]              sequence_accum_next;
  logic [15:0]              x_accum_next;
  logic [15:0]              y_accum_next;
  logic [15:0]              distance_accum_next;
  logic                     distance_negative_next;

  logic                     is_digit;
  logic [3:0]               digit;
  logic [15:0]              distance_val;
  logic                     is_nl;
  logic                     clear;

  assign is_digit = (rx_byte >= apl_pkg::CHAR_ZERO) && (rx_byte <= apl_pkg::CHAR_NINE);
  assign digit    = is_digit ? rx_byte[3:0] : 4'd0;
  assign is_nl    = (rx_byte == apl_pkg::CHAR_NL);
  assign distance_val = distance_negative ? (16'd0 - distance_accum) : distance_accum;

  assign res_fire = is_nl && (line_length != '0) &&
                    (phase inside {apl_pkg::PH_DSTART, apl_pkg::PH_DDIG, apl_pkg::PH_REST});

  always_comb begin
    res.mode         = mode_accum;
    res.sequence_res = sequence_accum;
    res.target_x     = x_accum;
    res.target_y     = y_accum;
    res.move_x       = x_accum - x_offset;
    res.move_y       = y_accum - y_offset;
    res.distance     = distance_val;
    res.target_valid = ~distance_val[15];
  end

  always_comb begin
    phase_next             = phase;
    line_length_next       = line_length + apl_pkg::LEN_W'(1);
    mode_accum_next        = mode_accum;
    sequence_accum_next    = sequence_accum;
    x_accum_next           = x_accum;
    y_accum_next           = y_accum;
    distance_accum_next    = distance_accum;
    distance_negative_next = distance_negative;
    clear = is_nl || (line_length >= apl_pkg::LEN_W'(MAX_LINE_LEN));
    case (phase)
      apl_pkg::PH_P: begin
        phase_next = (rx_byte == apl_pkg::CHAR_P) ? apl_pkg::PH_O : apl_pkg::PH_FAIL;
      end
      apl_pkg::PH_O: begin
        phase_next = (rx_byte == apl_pkg::CHAR_O) ? apl_pkg::PH_S : apl_pkg::PH_FAIL;
      end
      apl_pkg::PH_S: begin
        phase_next = (rx_byte == apl_pkg::CHAR_S) ? apl_pkg::PH_C : apl_pkg::PH_FAIL;
      end
      apl_pkg::PH_C: begin
        phase_next = (rx_byte == apl_pkg::CHAR_COMMA) ? apl_pkg::PH_MODE : apl_pkg::PH_FAIL;
      end
      apl_pkg::PH_MODE: begin
        if (is_digit) begin
          mode_accum_next = apl_pkg::dec8(mode_accum, digit);
        end else begin
          phase_next = (rx_byte == apl_pkg::CHAR_COMMA) ? apl_pkg::PH_SEQ : apl_pkg::PH_FAIL;
        end
      end
      apl_pkg::PH_SEQ: begin
        if (is_digit) begin
          sequence_accum_next = apl_pkg::dec16(sequence_accum, digit);
        end else begin
          phase_next = (rx_byte == apl_pkg::CHAR_COMMA) ? apl_pkg::PH_X : apl_pkg::PH_FAIL;
        end
      end
      apl_pkg::PH_X: begin
        if (is_digit) begin
          x_accum_next = apl_pkg::dec16(x_accum, digit);
        end else begin
          phase_next = (rx_byte == apl_pkg::CHAR_COMMA) ? apl_pkg::PH_Y : apl_pkg::PH_FAIL;
        end
      end
      apl_pkg::PH_Y: begin
        if (is_digit) begin
          y_accum_next = apl_pkg::dec16(y_accum, digit);
        end else begin
          phase_next = (rx_byte == apl_pkg::CHAR_COMMA) ? apl_pkg::PH_DSTART
                                                        : apl_pkg::PH_FAIL;
        end
      end
      apl_pkg::PH_DSTART: begin
        if (rx_byte == apl_pkg::CHAR_MINUS) begin
          distance_negative_next = 1'b1;
          phase_next             = apl_pkg::PH_DDIG;
        end else if (is_digit) begin
          distance_accum_next = apl_pkg::dec16(distance_accum, digit);
          phase_next          = apl_pkg::PH_DDIG;
        end else begin
          phase_next = apl_pkg::PH_REST;
        end
      end
      apl_pkg::PH_DDIG: begin
        if (is_digit) begin
          distance_accum_next = apl_pkg::dec16(distance_accum, digit);
        end else begin
          phase_next = apl_pkg::PH_REST;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (step && clear)) begin
      phase             <= apl_pkg::PH_P;
      line_length       <= '0;
      mode_accum        <= '0;
      sequence_accum    <= '0;
      x_accum           <= '0;
      y_accum           <= '0;
      distance_accum    <= '0;
      distance_negative <= 1'b0;
    end else if (step) begin
      phase             <= phase_next;
      line_length       <= line_length_next;
      mode_accum        <= mode_accum_next;
      sequence_accum    <= sequence_accum_next;
      x_accum           <= x_accum_next;
      y_accum           <= y_accum_next;
      distance_accum    <= distance_accum_next;
      distance_negative <= distance_negative_next;
    end
  end

endmodule

>>> rtl/core/apl_out_reg.sv
// ----------------------------------------------------------------------------
// apl_out_reg
// Result register that holds one parsed line until the sink takes it.
// ----------------------------------------------------------------------------
module apl_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  apl_pkg::result_t load_data,
  input  logic             ready,
  output logic             valid,
  output apl_pkg::result_t data
);

  logic valid_next;

  assign valid_next = load ? 1'b1 : (ready ? 1'b0 : valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule
